[rtl/three_wheel_omni_drive_mixer_defines.svh]
`ifndef THREE_WHEEL_OMNI_DRIVE_MIXER_DEFINES_SVH
`define THREE_WHEEL_OMNI_DRIVE_MIXER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define OMNI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OMNI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/omni_pkg.sv]
`default_nettype none

package omni_pkg;

  localparam int COS_BITS_DEF = 15;

  localparam int N_WHEELS = 3;
  localparam int COS_ROM_LEN = 91;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam longint ONE_Q30 = longint'(64'd1 << 30);

  localparam logic [63:0] TAYLOR_DIV [12] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
    64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
  };

  localparam logic [8:0] DEG_90  = 9'd90;
  localparam logic [8:0] DEG_180 = 9'd180;
  localparam logic [8:0] DEG_270 = 9'd270;
  localparam logic [8:0] DEG_360 = 9'd360;

  localparam logic [8:0] WHEEL_DEG [N_WHEELS] = '{9'd150, 9'd30, 9'd270};

  localparam logic [7:0] DUTY_MAX = 8'd255;

  typedef enum logic [1:0] {
    ACT_MOVE   = 2'd0,
    ACT_ROTATE = 2'd1,
    ACT_FULL   = 2'd2,
    ACT_STOP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BACK = 2'd2
  } dir_t;

  // quarter-wave cosine, 0..90 deg, unsigned Q1.cos_bits; elaboration only
  function automatic logic [63:0] quarter_cos(input int unsigned d,
                                              input int unsigned cos_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint sum;
    int unsigned shift;
    x = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    term = 64'd1 << 30;
    sum = ONE_Q30;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * x2 + (64'd1 << 29)) >> 30) / TAYLOR_DIV[k-1];
      if ((k & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > ONE_Q30) begin
      sum = ONE_Q30;
    end
    shift = 30 - cos_bits;
    return (64'(sum) + (64'd1 << (shift - 1))) >> shift;
  endfunction

endpackage

`default_nettype wire

[rtl/three_wheel_omni_drive_mixer.sv]
// channel  dir  tdata (low bit up)                                        tuser
// s_*      in   heading_deg[8:0] speed[17:9] turn_right[18]
//               motor_select[20:19], zero pad to 24                      action[1:0]
// m_*      out  duty_a[7:0] duty_b[15:8] duty_c[23:16] dir_a[25:24]
//               dir_b[27:26] dir_c[29:28], zero pad to 32                 -
//
// One word per cycle sustained while m_tready is high; the path runs through the input
// register, then the held duty/direction registers, which are the result register.
// Cosine lookup, three COS_BITS+1 by 9 multiplies and saturation sit in one stage.
// rst (sync, high) clears all duties to 0 and all directions to stop.
// A stalled m side holds the result; s_tready drops only when both stages are full.
`default_nettype none
`include "three_wheel_omni_drive_mixer_defines.svh"

module three_wheel_omni_drive_mixer
  import omni_pkg::*;
#(
  parameter int COS_BITS = COS_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // heading_deg, speed, turn_right, motor_select
  input  wire logic [1:0]  s_tuser,  // action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata   // duty_a, duty_b, duty_c, dir_a, dir_b, dir_c
);

  localparam int CW = COS_BITS + 1;
  localparam int PW = CW + 9;

  logic [CW-1:0] cos_rom [COS_ROM_LEN];

  for (genvar g = 0; g < COS_ROM_LEN; g++) begin : g_cos
    localparam logic [63:0] QC = quarter_cos(g, COS_BITS);
    assign cos_rom[g] = QC[CW-1:0];
  end

  logic              s1_valid;
  action_t           s1_action;
  logic [8:0]        s1_heading;
  logic signed [8:0] s1_speed;
  logic              s1_turn_right;
  logic [1:0]        s1_sel;

  logic [7:0] duty [N_WHEELS];
  dir_t       dir  [N_WHEELS];
  logic [7:0] duty_next [N_WHEELS];
  dir_t       dir_next  [N_WHEELS];

  logic take;
  logic adv;

  assign adv      = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || adv;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_action     <= action_t'(s_tuser);
      s1_heading    <= s_tdata[8:0];
      s1_speed      <= s_tdata[17:9];
      s1_turn_right <= s_tdata[18];
      s1_sel        <= s_tdata[20:19];
    end
  end

  always_comb begin
    logic [8:0]    head;
    logic [9:0]    diff;
    logic [8:0]    ang;
    logic [6:0]    idx;
    logic          neg;
    logic [CW-1:0] cval;
    logic [8:0]    mag;
    logic [PW-1:0] prod;
    logic [9:0]    draw;
    logic [7:0]    rot;
    head = (s1_heading >= DEG_360) ? s1_heading - DEG_360 : s1_heading;
    mag  = s1_speed[8] ? 9'(-s1_speed) : 9'(s1_speed);
    rot  = s1_speed[8] ? 8'd0 : s1_speed[7:0];
    for (int i = 0; i < N_WHEELS; i++) begin
      diff = {1'b0, WHEEL_DEG[i]} - {1'b0, head};
      ang  = diff[9] ? 9'(diff + {1'b0, DEG_360}) : diff[8:0];
      if (ang <= DEG_90) begin
        idx = ang[6:0];
        neg = 1'b0;
      end else if (ang <= DEG_180) begin
        idx = 7'(DEG_180 - ang);
        neg = 1'b1;
      end else if (ang <= DEG_270) begin
        idx = 7'(ang - DEG_180);
        neg = 1'b1;
      end else begin
        idx = 7'(DEG_360 - ang);
        neg = 1'b0;
      end
      cval = cos_rom[idx];
      prod = PW'(cval) * PW'(mag);
      draw = prod[PW-1:COS_BITS];
      duty_next[i] = duty[i];
      dir_next[i]  = dir[i];
      case (s1_action)
        ACT_MOVE: begin
          duty_next[i] = (draw > 10'(DUTY_MAX)) ? DUTY_MAX : draw[7:0];
          dir_next[i]  = (neg && cval != '0) ? DIR_BACK : DIR_FWD;
        end
        ACT_ROTATE: begin
          duty_next[i] = rot;
          dir_next[i]  = s1_turn_right ? DIR_BACK : DIR_FWD;
        end
        ACT_FULL: begin
          if (s1_sel == 2'(i + 1)) begin
            duty_next[i] = DUTY_MAX;
            dir_next[i]  = DIR_FWD;
          end
        end
        ACT_STOP: begin
          dir_next[i] = DIR_STOP;
        end
        default: begin
          dir_next[i] = dir[i];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N_WHEELS; i++) begin
        duty[i] <= '0;
        dir[i]  <= DIR_STOP;
      end
    end else if (adv) begin
      for (int i = 0; i < N_WHEELS; i++) begin
        duty[i] <= duty_next[i];
        dir[i]  <= dir_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {2'b00, dir[2], dir[1], dir[0], duty[2], duty[1], duty[0]};

  `OMNI_ASSERT_NEXT(a_stop_dirs, adv && s1_action == ACT_STOP, dir[0] == DIR_STOP && dir[1] == DIR_STOP && dir[2] == DIR_STOP, "stop left a motor running")
  `OMNI_ASSERT_NEXT(a_stop_duty, adv && s1_action == ACT_STOP, duty[0] == $past(duty[0]) && duty[1] == $past(duty[1]) && duty[2] == $past(duty[2]), "stop changed a duty")
  `OMNI_ASSERT_NEXT(a_rot_right, adv && s1_action == ACT_ROTATE && s1_turn_right, dir[0] == DIR_BACK && dir[1] == DIR_BACK && dir[2] == DIR_BACK, "right rotate not all backward")
  `OMNI_ASSERT_NEXT(a_hold_idle, !adv, $stable(duty[0]) && $stable(duty[1]) && $stable(duty[2]) && $stable(m_tdata), "held state moved without a word")
  `OMNI_ASSERT_NOW(a_adv_frees, adv, s_tready, "input blocked while stage drains")

endmodule

`default_nettype wire
